FILE: rtl/mos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mos_pkg: shared types for the sample median block
// Word type of one sample and the control group that steers the cell row.
// ----------------------------------------------------------------------------
package mos_pkg;

    localparam int WORD_W = 32;
    localparam int CFG_W  = 5;

    typedef logic signed [WORD_W-1:0] mos_word_t;
    typedef logic [CFG_W-1:0]         mos_cfg_t;

    // Row-wide command: load a new sample in sorted place, or move every
    // cell one place toward cell 0.
    typedef struct packed {
        logic insert;
        logic shift;
    } mos_cell_ctrl_t;

endpackage

FILE: rtl/mos_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mos_sample_if: sample request channel
// Valid/ready channel that carries one signed converter sample.
// ----------------------------------------------------------------------------
interface mos_sample_if;
    logic               valid;
    logic               ready;
    mos_pkg::mos_word_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/mos_median_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mos_median_if: median result channel
// Valid/ready channel that carries one signed median.
// ----------------------------------------------------------------------------
interface mos_median_if;
    logic               valid;
    logic               ready;
    mos_pkg::mos_word_t median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

FILE: rtl/median_of_samples.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_of_samples: streaming median over sets of signed samples
// Sorts each set into a row of insertion cells and reports its median.
// ----------------------------------------------------------------------------
//
//  channel          dir  handshake       payload
//  sample_stream    in   valid / ready   sample  [31:0] signed
//  median_stream    out  valid / ready   median  [31:0] signed
//  cfg              in   cfg_wr_en       cfg_wr_data [4:0]  (samples per set)
//
// A sample that does not complete a set is taken without ready going low; the next one
// may follow at once. A completing sample holds ready low while the cell row
// shifts the lower middle element into cell 0, where any shift is needed, and
// while the block passes through its sum and emit states.
// The emit cycle waits while the output register still holds an untaken
// median. Reset empties the set and sets the set size to 16; the cell
// contents are not cleared, since only places below the fill count are read.
// ----------------------------------------------------------------------------
module median_of_samples #(
    parameter int MAX_SAMPLES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    mos_sample_if.sink         sample_stream,
    mos_median_if.source       median_stream,
    input  logic               cfg_wr_en,
    input  mos_pkg::mos_cfg_t  cfg_wr_data
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);           // fill count width
    localparam int SW = (CW > mos_pkg::CFG_W) ? CW : mos_pkg::CFG_W;
    localparam logic [SW-1:0] MAX_S = SW'(MAX_SAMPLES);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SHIFT = 4'b0010,
        ST_SUM   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    mos_pkg::mos_cfg_t  size_cfg_reg, size_cfg_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      shift_cnt_reg, shift_cnt_next;
    logic [32:0]        sum_reg, sum_next;
    logic               odd_reg, odd_next;
    logic               out_valid_reg, out_valid_next;
    mos_pkg::mos_word_t median_reg, median_next;

    mos_pkg::mos_cell_ctrl_t ctrl;
    logic                    accept;
    logic                    can_insert;
    logic [CW-1:0]           count_inc;
    logic [CW-1:0]           half_idx;
    logic [SW-1:0]           set_size;
    logic                    set_done;
    logic                    out_free;
    logic [32:0]             rounded;

    logic               gt_w    [MAX_SAMPLES];
    mos_pkg::mos_word_t value_w [MAX_SAMPLES];

    // ------------------------------------------------------------------
    // Cell row: cell i holds the i-th smallest sample of the set.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAX_SAMPLES; i++)
    begin : g_cell
        logic               prev_gt;
        mos_pkg::mos_word_t prev_value;
        mos_pkg::mos_word_t next_value;

        if (i == 0)
        begin : g_head
            assign prev_gt    = 1'b0;
            assign prev_value = '0;
        end
        else
        begin : g_body
            assign prev_gt    = gt_w[i-1];
            assign prev_value = value_w[i-1];
        end

        if (i == MAX_SAMPLES - 1)
        begin : g_last
            assign next_value = '0;
        end
        else
        begin : g_inner
            assign next_value = value_w[i+1];
        end

        mos_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (CW'(i) < count_reg),
            .is_tail    (CW'(i) == count_reg),
            .sample     (sample_stream.sample),
            .prev_gt    (prev_gt),
            .prev_value (prev_value),
            .next_value (next_value),
            .gt         (gt_w[i]),
            .value      (value_w[i])
        );
    end

    // ------------------------------------------------------------------
    // Set size: zero counts as one, anything above the row saturates.
    // ------------------------------------------------------------------
    always_comb
    begin
        set_size = SW'(size_cfg_reg);
        if (size_cfg_reg == '0)
        begin
            set_size = SW'(1);
        end
        if (set_size > MAX_S)
        begin
            set_size = MAX_S;
        end
    end

    assign accept     = sample_stream.valid && sample_stream.ready;
    assign can_insert = count_reg < CW'(MAX_SAMPLES);
    assign count_inc  = can_insert ? count_reg + CW'(1) : count_reg;
    assign set_done   = SW'(count_inc) >= set_size;
    // Shifts needed to bring the lower middle element into cell 0.
    assign half_idx   = (count_inc - CW'(1)) >> 1;
    assign out_free   = !out_valid_reg || median_stream.ready;

    // Halve toward zero: bias a negative sum by one before the arithmetic shift.
    assign rounded = sum_reg + {32'd0, sum_reg[32]};

    assign ctrl.insert = accept && can_insert;
    assign ctrl.shift  = (state_reg == ST_SHIFT);

    assign sample_stream.ready = (state_reg == ST_IDLE);
    assign median_stream.valid = out_valid_reg;
    assign median_stream.median = median_reg;

    always_comb
    begin
        state_next     = state_reg;
        size_cfg_next  = cfg_wr_en ? cfg_wr_data : size_cfg_reg;
        count_next     = count_reg;
        shift_cnt_next = shift_cnt_reg;
        sum_next       = sum_reg;
        odd_next       = odd_reg;
        out_valid_next = out_valid_reg;
        median_next    = median_reg;

        // Drop the held median once the sink takes it.
        if (median_stream.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (set_done)
                    begin
                        // Empty the set now; the row keeps its values for readout.
                        count_next     = '0;
                        odd_next       = count_inc[0];
                        shift_cnt_next = half_idx;
                        state_next     = (half_idx == '0) ? ST_SUM : ST_SHIFT;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
            end
            ST_SHIFT:
            begin
                shift_cnt_next = shift_cnt_reg - CW'(1);
                if (shift_cnt_reg == CW'(1))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                // Odd set: double the middle so the common halving returns it.
                if (odd_reg)
                begin
                    sum_next = {value_w[0], 1'b0};
                end
                else if (MAX_SAMPLES > 1)
                begin
                    sum_next = {value_w[0][31], value_w[0]}
                             + {value_w[MAX_SAMPLES > 1 ? 1 : 0][31],
                                value_w[MAX_SAMPLES > 1 ? 1 : 0]};
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    median_next    = mos_pkg::mos_word_t'(rounded[32:1]);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_cfg_reg  <= mos_pkg::mos_cfg_t'(16);
            count_reg     <= '0;
            shift_cnt_reg <= '0;
            odd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_cfg_reg  <= size_cfg_next;
            count_reg     <= count_next;
            shift_cnt_reg <= shift_cnt_next;
            odd_reg       <= odd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        median_reg <= median_next;
    end

endmodule

FILE: rtl/mos_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mos_cell: one place of the sorted insertion row
// Holds one sample; takes the new sample, its left neighbor or its right
// neighbor depending on the row command and the neighbor compare.
// ----------------------------------------------------------------------------
module mos_cell (
    input  logic                    clk,
    input  mos_pkg::mos_cell_ctrl_t ctrl,
    input  logic                    occupied,
    input  logic                    is_tail,
    input  mos_pkg::mos_word_t      sample,
    input  logic                    prev_gt,
    input  mos_pkg::mos_word_t      prev_value,
    input  mos_pkg::mos_word_t      next_value,
    output logic                    gt,
    output mos_pkg::mos_word_t      value
);

    mos_pkg::mos_word_t value_reg;
    mos_pkg::mos_word_t value_next;

    // Strictly greater: equal samples stay ahead of the newcomer.
    assign gt    = occupied && (value_reg > sample);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift)
        begin
            value_next = next_value;
        end
        else if (ctrl.insert && (gt || is_tail))
        begin
            // Move the left neighbor in when it also yields, else take the sample.
            value_next = prev_gt ? prev_value : sample;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: sim/median_of_samples_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_of_samples_tb: self-checking bench for the sample median block
// Streams sets of signed samples under random stalls on both channels and
// checks every median against a sorted-set predictor kept in the bench.
// ----------------------------------------------------------------------------
module median_of_samples_tb;

    localparam int MAX_SAMPLES  = 16;
    localparam int RANDOM_ITEMS = 1625;
    // Quiet time covers the ready hold of the worst completing request at size 16.
    localparam int QUIET        = 12;
    localparam int DRAIN        = 30;
    localparam int HOLD_OFF     = 400;
    localparam int IDLE_LIMIT   = 5000;
    localparam int PLAN_LEN     = 30;

    localparam mos_pkg::mos_word_t W_MAX = 32'sh7FFF_FFFF;
    localparam mos_pkg::mos_word_t W_MIN = 32'sh8000_0000;

    typedef enum logic {ROW_SIZE, ROW_SAMPLE} row_kind_t;

    // One line of the directed plan: either a set-size write or a sample.
    // A pinned row carries the median that its sample must produce.
    typedef struct {
        row_kind_t          kind;
        mos_pkg::mos_word_t value;
        bit                 pinned;
        mos_pkg::mos_word_t median;
    } row_t;

    // Directed plan: reset size of 16 held off by ten samples, then lowered
    // mid-set to 4 so the eleventh closes a set of eleven; single-sample sets
    // at the word limits; size zero acting as one; pairs at the word limits
    // whose sums would overflow 32 bits, a pair whose mean truncates toward
    // zero, a pair of both word limits; equal samples in a set of three.
    row_t plan [PLAN_LEN] = '{
        '{ROW_SAMPLE, 8,     1'b0, 0},
        '{ROW_SAMPLE, W_MAX, 1'b0, 0},
        '{ROW_SAMPLE, 3,     1'b0, 0},
        '{ROW_SAMPLE, W_MIN, 1'b0, 0},
        '{ROW_SAMPLE, 6,     1'b0, 0},
        '{ROW_SAMPLE, 1,     1'b0, 0},
        '{ROW_SAMPLE, 5,     1'b0, 0},
        '{ROW_SAMPLE, 2,     1'b0, 0},
        '{ROW_SAMPLE, 7,     1'b0, 0},
        '{ROW_SAMPLE, 4,     1'b0, 0},
        '{ROW_SIZE,   4,     1'b0, 0},
        '{ROW_SAMPLE, 0,     1'b1, 4},
        '{ROW_SIZE,   1,     1'b0, 0},
        '{ROW_SAMPLE, W_MAX, 1'b1, W_MAX},
        '{ROW_SAMPLE, W_MIN, 1'b1, W_MIN},
        '{ROW_SIZE,   0,     1'b0, 0},
        '{ROW_SAMPLE, 5,     1'b1, 5},
        '{ROW_SIZE,   2,     1'b0, 0},
        '{ROW_SAMPLE, W_MAX, 1'b0, 0},
        '{ROW_SAMPLE, W_MAX, 1'b1, W_MAX},
        '{ROW_SAMPLE, W_MIN, 1'b0, 0},
        '{ROW_SAMPLE, W_MIN, 1'b1, W_MIN},
        '{ROW_SAMPLE, -1,    1'b0, 0},
        '{ROW_SAMPLE, -2,    1'b1, -1},
        '{ROW_SAMPLE, W_MAX, 1'b0, 0},
        '{ROW_SAMPLE, W_MIN, 1'b1, 0},
        '{ROW_SIZE,   3,     1'b0, 0},
        '{ROW_SAMPLE, 9,     1'b0, 0},
        '{ROW_SAMPLE, 9,     1'b0, 0},
        '{ROW_SAMPLE, 1,     1'b1, 9}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    mos_pkg::mos_cfg_t cfg_wr_data;

    // Pinned expectation travels alongside the sample request it belongs to.
    logic               pin_on;
    mos_pkg::mos_word_t pin_value;

    mos_sample_if sample_bus ();
    mos_median_if median_bus ();

    median_of_samples #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_stream (sample_bus),
        .median_stream (median_bus),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state: the held set in ascending order and the size register.
    mos_pkg::mos_word_t held [$];
    mos_pkg::mos_cfg_t  size_reg = 5'd16;
    mos_pkg::mos_word_t medians_due [$];

    int  errors        = 0;
    int  samples_in    = 0;
    int  medians_out   = 0;
    int  sizes_written = 0;
    int  idle_cycles   = 0;
    logic [31:0] sizes_seen = '0;
    bit  choke_pending = 1'b0;

    // Zero acts as one; anything past the store depth saturates.
    function automatic int set_len(input mos_pkg::mos_cfg_t v);
        if (v == 0)
            return 1;
        if (v > MAX_SAMPLES)
            return MAX_SAMPLES;
        return int'(v);
    endfunction

    // Insert one sample after any equal ones; when the set is complete,
    // return its median and empty the set.
    function automatic bit place_sample(input mos_pkg::mos_word_t s,
                                        output mos_pkg::mos_word_t m);
        int     pos;
        int     n;
        longint pair;
        m = '0;
        if (held.size() < MAX_SAMPLES)
        begin
            pos = held.size();
            while (pos > 0 && held[pos-1] > s)
                pos--;
            held.insert(pos, s);
        end
        n = held.size();
        if (n < set_len(size_reg))
            return 1'b0;
        if (n % 2 == 1)
            m = held[n/2];
        else
        begin
            // Sum at 64 bits; SV division truncates toward zero.
            pair = longint'(held[(n-1)/2]) + longint'(held[n/2]);
            m = mos_pkg::mos_word_t'(pair / 2);
        end
        held.delete();
        return 1'b1;
    endfunction

    function automatic mos_pkg::mos_word_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return W_MAX - mos_pkg::mos_word_t'($urandom_range(0, 3));
            3:       return W_MIN + mos_pkg::mos_word_t'($urandom_range(0, 3));
            // Narrow band: plenty of equal samples within one set.
            4, 5:    return mos_pkg::mos_word_t'($urandom_range(0, 16)) - 8;
            default: return mos_pkg::mos_word_t'($urandom);
        endcase
    endfunction

    function automatic int next_gap(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 10));
    endfunction

    // Observe both channels and the size port at every edge. Requests are
    // predicted before results are checked, so the order is fixed.
    always @(posedge clk)
    begin : watch
        mos_pkg::mos_word_t m;
        mos_pkg::mos_word_t due;
        bit                 busy;
        busy = 1'b0;
        if (rst_n)
        begin
            if (cfg_wr_en)
                size_reg = cfg_wr_data;
            if (sample_bus.valid && sample_bus.ready)
            begin
                busy = 1'b1;
                samples_in++;
                if (place_sample(sample_bus.sample, m))
                    medians_due.push_back(pin_on ? pin_value : m);
                else if (pin_on)
                begin
                    $error("median: expected %0d, predictor closes no set", pin_value);
                    errors++;
                end
            end
            if (median_bus.valid && median_bus.ready)
            begin
                busy = 1'b1;
                medians_out++;
                if (medians_due.size() == 0)
                begin
                    $error("median: expected none, got %0d", median_bus.median);
                    errors++;
                end
                else
                begin
                    due = medians_due.pop_front();
                    if (median_bus.median !== due)
                    begin
                        $error("median: expected %0d, got %0d", due, median_bus.median);
                        errors++;
                    end
                end
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: %0d cycles without a request or a median",
                         idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Offer one sample request after a gap; hold valid until it is taken.
    task automatic send_sample(input mos_pkg::mos_word_t s, input bit pinned,
                               input mos_pkg::mos_word_t pin_val, input int gap);
        if (gap > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= s;
        pin_on            <= pinned;
        pin_value         <= pin_val;
        do
            @(posedge clk);
        while (!sample_bus.ready);
    endtask

    // Drop valid, let every due median drain, then let a non-closing
    // request finish its insertion before touching the size register.
    task automatic settle();
        sample_bus.valid <= 1'b0;
        @(posedge clk);
        while (medians_due.size() != 0)
            @(posedge clk);
        repeat (QUIET) @(posedge clk);
    endtask

    task automatic write_size(input mos_pkg::mos_cfg_t v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        sizes_seen[v] = 1'b1;
        sizes_written++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Sender: directed plan first, then random phases, each one a size write
    // followed by whole sets and sometimes a partial set left open, so the
    // next write lands mid-set.
    initial
    begin
        mos_pkg::mos_cfg_t size;
        int                span;
        int                n_items;
        int                fed;
        int                phase;
        bit                calm;
        fed   = 0;
        phase = 0;
        sample_bus.valid  = 1'b0;
        sample_bus.sample = '0;
        pin_on            = 1'b0;
        pin_value         = '0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        rst_n             = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_SIZE)
                write_size(mos_pkg::mos_cfg_t'(plan[i].value));
            else
                send_sample(plan[i].value, plan[i].pinned, plan[i].median,
                            next_gap(1'b0));
        end

        while (fed < RANDOM_ITEMS)
        begin
            if (phase == 4)
            begin
                // Back-pressure phase: one-sample sets sent back to back
                // while the median side holds off, so the input stalls.
                write_size(5'd1);
                choke_pending = 1'b1;
                calm          = 1'b1;
                n_items       = 40;
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0:       size = 5'd0;
                    1:       size = 5'd1;
                    2:       size = 5'd16;
                    3:       size = mos_pkg::mos_cfg_t'($urandom_range(17, 31));
                    4:       size = 5'd31;
                    default: size = mos_pkg::mos_cfg_t'($urandom_range(2, 15));
                endcase
                write_size(size);
                span    = set_len(size);
                n_items = span * int'($urandom_range(1, 5));
                if ($urandom_range(0, 3) == 0)
                    n_items += int'($urandom_range(0, span - 1));
                calm = ($urandom_range(0, 3) == 0);
            end
            repeat (n_items)
                send_sample(pick_sample(), 1'b0, '0, next_gap(calm));
            fed += n_items;
            phase++;
        end

        settle();
        repeat (DRAIN) @(posedge clk);

        if (medians_due.size() != 0)
        begin
            $error("median: %0d expected medians never arrived", medians_due.size());
            errors++;
        end
        $display("covered %0d samples and %0d medians over %0d size writes",
                 samples_in, medians_out, sizes_written);
        $display("distinct set sizes written: %0d of 32, mismatches: %0d",
                 $countones(sizes_seen), errors);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Receiver: draw a stall before each median, flip into stall-free
    // stretches now and then, and take the long hold-off when asked.
    initial
    begin
        int wait_n;
        bit calm;
        calm = 1'b0;
        median_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (choke_pending)
            begin
                choke_pending = 1'b0;
                wait_n = HOLD_OFF;
            end
            else
            begin
                if ($urandom_range(0, 24) == 0)
                    calm = !calm;
                wait_n = next_gap(calm);
            end
            if (wait_n > 0)
            begin
                median_bus.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            median_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(median_bus.valid && median_bus.ready));
        end
    end

endmodule
